/* hw/rtl/itchdmp_pkg.sv */
// ----------------------------------------------------------------------------
// itchdmp_pkg
// shared constants, message codes and record type of the itch datagram parser
// ----------------------------------------------------------------------------
package itchdmp_pkg;

    localparam int MAX_DATAGRAM_BYTES = 2048;
    localparam int HEADER_BYTES       = 20;
    localparam int POS_W              = $clog2(MAX_DATAGRAM_BYTES + 1);
    localparam int OFS_W              = 17;

    // message type bytes
    localparam logic [7:0] TYPE_ADD      = 8'h41;
    localparam logic [7:0] TYPE_ADD_MPID = 8'h46;
    localparam logic [7:0] TYPE_EXEC     = 8'h45;
    localparam logic [7:0] TYPE_EXEC_PX  = 8'h43;
    localparam logic [7:0] TYPE_CANCEL   = 8'h58;
    localparam logic [7:0] TYPE_DELETE   = 8'h44;
    localparam logic [7:0] TYPE_REPLACE  = 8'h55;

    // expected message lengths
    localparam logic [5:0] LEN_ADD      = 6'd36;
    localparam logic [5:0] LEN_ADD_MPID = 6'd40;
    localparam logic [5:0] LEN_EXEC     = 6'd31;
    localparam logic [5:0] LEN_EXEC_PX  = 6'd36;
    localparam logic [5:0] LEN_CANCEL   = 6'd23;
    localparam logic [5:0] LEN_DELETE   = 6'd19;
    localparam logic [5:0] LEN_REPLACE  = 6'd35;

    // byte positions inside a message, type byte at zero
    localparam int ID_START      = 11;
    localparam int ADD_SIDE      = 19;
    localparam int ADD_QTY       = 20;
    localparam int ADD_PRICE     = 32;
    localparam int EXEC_QTY      = 19;
    localparam int REPL_NEW_ID   = 19;
    localparam int REPL_QTY      = 27;
    localparam int REPL_PRICE    = 31;

    typedef enum logic [2:0] {
        KIND_ADD     = 3'd0,
        KIND_EXEC    = 3'd1,
        KIND_CANCEL  = 3'd2,
        KIND_DELETE  = 3'd3,
        KIND_REPLACE = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind        message_kind;
        logic [63:0]  order_ref;
        logic [63:0]  new_order_ref;
        logic [31:0]  price;
        logic [31:0]  quantity;
        logic [7:0]   side;
    } t_record;

    function automatic logic [5:0] table_length(input logic [7:0] t);
        logic [5:0] len;
        case (t)
            TYPE_ADD:      len = LEN_ADD;
            TYPE_ADD_MPID: len = LEN_ADD_MPID;
            TYPE_EXEC:     len = LEN_EXEC;
            TYPE_EXEC_PX:  len = LEN_EXEC_PX;
            TYPE_CANCEL:   len = LEN_CANCEL;
            TYPE_DELETE:   len = LEN_DELETE;
            TYPE_REPLACE:  len = LEN_REPLACE;
            default:       len = 6'd0;
        endcase
        return len;
    endfunction

    function automatic t_kind kind_of(input logic [7:0] t);
        t_kind k;
        case (t)
            TYPE_ADD, TYPE_ADD_MPID: k = KIND_ADD;
            TYPE_EXEC, TYPE_EXEC_PX: k = KIND_EXEC;
            TYPE_CANCEL:             k = KIND_CANCEL;
            TYPE_DELETE:             k = KIND_DELETE;
            default:                 k = KIND_REPLACE;
        endcase
        return k;
    endfunction

endpackage

/* hw/rtl/itchdmp_parse_core.sv */
// ----------------------------------------------------------------------------
// itchdmp_parse_core
// datagram parse state and one-byte update, record built from next state
// ----------------------------------------------------------------------------
module itchdmp_parse_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_rec_valid,
    output itchdmp_pkg::t_record o_rec
);
    import itchdmp_pkg::*;

    logic [POS_W-1:0] r_pos,     n_pos;
    logic [15:0]      r_decl,    n_decl;
    logic [15:0]      r_seen,    n_seen;
    logic [15:0]      r_len,     n_len;
    logic [OFS_W-1:0] r_offset,  n_offset;
    logic [7:0]       r_type,    n_type;
    logic             r_acc,     n_acc;
    logic [63:0]      r_first,   n_first;
    logic [63:0]      r_second,  n_second;
    logic [31:0]      r_price,   n_price;
    logic [31:0]      r_qty,     n_qty;
    logic [7:0]       r_side,    n_side;
    logic [OFS_W-1:0] msg_idx;
    logic [5:0]       tbl_len;
    logic             rec_valid;

    always_comb begin
        n_pos     = r_pos;
        n_decl    = r_decl;
        n_seen    = r_seen;
        n_len     = r_len;
        n_offset  = r_offset;
        n_type    = r_type;
        n_acc     = r_acc;
        n_first   = r_first;
        n_second  = r_second;
        n_price   = r_price;
        n_qty     = r_qty;
        n_side    = r_side;
        rec_valid = 1'b0;
        msg_idx   = r_offset - OFS_W'(2);
        tbl_len   = table_length(i_data_byte);

        if (r_pos < POS_W'(MAX_DATAGRAM_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
            if (r_pos < POS_W'(HEADER_BYTES)) begin
                if (r_pos == POS_W'(HEADER_BYTES - 2)) begin
                    n_decl = {i_data_byte, 8'h00};
                end else if (r_pos == POS_W'(HEADER_BYTES - 1)) begin
                    n_decl = {r_decl[15:8], i_data_byte};
                end
            end else if (r_offset == '0) begin
                // length high byte opens a new message
                if (r_seen < r_decl) begin
                    n_seen   = r_seen + 16'd1;
                    n_len    = {i_data_byte, 8'h00};
                    n_type   = 8'h00;
                    n_acc    = 1'b0;
                    n_first  = '0;
                    n_second = '0;
                    n_price  = '0;
                    n_qty    = '0;
                    n_side   = '0;
                    n_offset = OFS_W'(1);
                end
            end else begin
                if (r_offset == OFS_W'(1)) begin
                    n_len = {r_len[15:8], i_data_byte};
                end else if (r_offset == OFS_W'(2)) begin
                    n_type = i_data_byte;
                    n_acc  = (tbl_len != 6'd0) && ({10'd0, tbl_len} == r_len);
                end else if (r_acc) begin
                    for (int j = 0; j < 8; j++) begin
                        if (msg_idx == OFS_W'(ID_START + j))
                            n_first[8*j +: 8] = i_data_byte;
                    end
                    case (r_type)
                        TYPE_ADD, TYPE_ADD_MPID: begin
                            if (msg_idx == OFS_W'(ADD_SIDE))
                                n_side = i_data_byte;
                            for (int j = 0; j < 4; j++) begin
                                if (msg_idx == OFS_W'(ADD_QTY + j))
                                    n_qty[8*j +: 8] = i_data_byte;
                                if (msg_idx == OFS_W'(ADD_PRICE + j))
                                    n_price[8*j +: 8] = i_data_byte;
                            end
                        end
                        TYPE_EXEC, TYPE_EXEC_PX, TYPE_CANCEL: begin
                            for (int j = 0; j < 4; j++) begin
                                if (msg_idx == OFS_W'(EXEC_QTY + j))
                                    n_qty[8*j +: 8] = i_data_byte;
                            end
                        end
                        TYPE_REPLACE: begin
                            for (int j = 0; j < 8; j++) begin
                                if (msg_idx == OFS_W'(REPL_NEW_ID + j))
                                    n_second[8*j +: 8] = i_data_byte;
                            end
                            for (int j = 0; j < 4; j++) begin
                                if (msg_idx == OFS_W'(REPL_QTY + j))
                                    n_qty[8*j +: 8] = i_data_byte;
                                if (msg_idx == OFS_W'(REPL_PRICE + j))
                                    n_price[8*j +: 8] = i_data_byte;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                // last byte of the message body
                if (r_offset == {1'b0, n_len} + OFS_W'(1)) begin
                    n_offset  = '0;
                    rec_valid = n_acc;
                end else begin
                    n_offset = r_offset + OFS_W'(1);
                end
            end
        end
    end

    assign o_rec_valid          = rec_valid;
    assign o_rec.message_kind   = kind_of(n_type);
    assign o_rec.order_ref      = n_first;
    assign o_rec.new_order_ref  = (n_type == TYPE_REPLACE) ? n_second : 64'd0;
    assign o_rec.price          = n_price;
    assign o_rec.quantity       = n_qty;
    assign o_rec.side           = n_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last_byte)) begin
            r_pos    <= '0;
            r_decl   <= '0;
            r_seen   <= '0;
            r_len    <= '0;
            r_offset <= '0;
            r_type   <= '0;
            r_acc    <= 1'b0;
            r_first  <= '0;
            r_second <= '0;
            r_price  <= '0;
            r_qty    <= '0;
            r_side   <= '0;
        end else if (i_en) begin
            r_pos    <= n_pos;
            r_decl   <= n_decl;
            r_seen   <= n_seen;
            r_len    <= n_len;
            r_offset <= n_offset;
            r_type   <= n_type;
            r_acc    <= n_acc;
            r_first  <= n_first;
            r_second <= n_second;
            r_price  <= n_price;
            r_qty    <= n_qty;
            r_side   <= n_side;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_DATAGRAM_BYTES))
        else $error("datagram position past size limit");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= r_decl)
        else $error("more messages started than declared");

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= {1'b0, r_len} + OFS_W'(1))
        else $error("offset ran past end of message");

    a_rec_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && rec_valid |=> r_offset == '0)
        else $error("record emitted without closing the message");

    a_rec_needs_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && rec_valid && (r_offset != OFS_W'(2)) |-> r_acc)
        else $error("record from a message that was not accepted");

endmodule

/* hw/rtl/itch_datagram_message_parser_unit.sv */
// ----------------------------------------------------------------------------
// itch_datagram_message_parser_unit
// Byte-serial parser for a market data datagram: a 20-byte header whose last
// two bytes carry the big-endian message count, then a chain of messages each
// led by a big-endian 2-byte length. One byte is taken per cycle while the
// input is not stalled, since each byte is a single short state update; a
// record for an add (A/F), executed (E/C), cancel (X), delete (D) or replace
// (U) message of the expected length is presented on the output once its final
// byte has passed the input register and then the result register. Any
// other message, a message cut off by the end of the datagram or the size
// limit, and every message past the declared count give nothing. Bytes at or
// beyond the size limit are dropped, but their last_byte flag still ends the
// datagram and returns the parser to its reset state. Multi-byte record
// fields carry the first wire byte in the least significant position. The
// input side stalls only while a finished record waits and the input
// register is already full.
// ----------------------------------------------------------------------------
module itch_datagram_message_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // record out
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_message_kind,
    output logic [63:0] o_order_ref,
    output logic [63:0] o_new_order_ref,
    output logic [31:0] o_price,
    output logic [31:0] o_quantity,
    output logic [7:0]  o_side
);
    import itchdmp_pkg::*;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // result register
    logic        r_out_valid;
    t_record     r_rec;

    logic        adv;        // result register can load this cycle
    logic        in_take;    // item accepted on the input side
    logic        core_en;    // buffered byte is parsed this cycle
    logic        rec_valid;
    t_record     rec;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !adv;
    assign in_take = i_valid && !o_stall;
    assign core_en = r_in_valid && adv;

    // parse state lives here; advances only when the byte moves on
    itchdmp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (core_en),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    // control: valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && rec_valid;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (core_en && rec_valid) begin
            r_rec <= rec;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_message_kind  = r_rec.message_kind;
    assign o_order_ref     = r_rec.order_ref;
    assign o_new_order_ref = r_rec.new_order_ref;
    assign o_price         = r_rec.price;
    assign o_quantity      = r_rec.quantity;
    assign o_side          = r_rec.side;

endmodule
